// ===== rtl/smrd_pkg.sv =====
// Shared constants, codes and types for the stereo mean / RMS decimator.
`default_nettype none

package smrd_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS = 16;
    localparam int WIDTH_BITS  = 16;
    localparam int ACC_BITS    = 48;
    localparam int LEVEL_BITS  = 17;
    localparam int INDEX_BITS  = 16;
    localparam int ROOT_BITS   = ACC_BITS / 2;

    // Result word: level and bucket index, padded to whole bytes
    localparam int OUT_RAW  = LEVEL_BITS + INDEX_BITS;
    localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8;

    // Reset values of the configuration registers
    localparam int BUCKET_WIDTH_RESET  = 1;
    localparam int RMS_THRESHOLD_RESET = 10;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BUCKET_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RMS_THRESHOLD = 2'd1;

    // Shared iteration unit: step counts and operation codes
    localparam int DIV_STEPS  = ACC_BITS;
    localparam int SQRT_STEPS = ACC_BITS / 2;
    localparam int STEP_BITS  = $clog2(DIV_STEPS);

    localparam logic OP_DIV  = 1'b0;
    localparam logic OP_SQRT = 1'b1;

    // Command into the iteration unit
    typedef struct packed {
        logic start;
        logic op;
    } t_iter_cmd;

endpackage

`default_nettype wire

// ===== rtl/smrd_iter.sv =====
// Shared iterative unit: restoring divide (one bit a cycle) and square root (one digit a cycle).
`default_nettype none

module smrd_iter
    import smrd_pkg::*;
#(
    parameter int WIDTH_BITS = smrd_pkg::WIDTH_BITS,
    // Remainder wide enough for both the divisor and the partial root
    parameter int REM_BITS   = (WIDTH_BITS + 3 > ROOT_BITS + 4) ? WIDTH_BITS + 3 : ROOT_BITS + 4
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire  t_iter_cmd               i_cmd,
    input  wire        [ACC_BITS-1:0]     i_num,
    input  wire        [WIDTH_BITS+1:0]   i_den,
    output logic                          o_done,
    output logic       [ACC_BITS-1:0]     o_quo,
    output logic       [REM_BITS-1:0]     o_rem
);

    logic                    r_busy;
    logic                    r_done;
    logic                    r_op;
    logic [STEP_BITS-1:0]    r_cnt;
    logic [ACC_BITS-1:0]     r_x;
    logic [ACC_BITS-1:0]     r_quo;
    logic [REM_BITS-1:0]     r_rem;
    logic [WIDTH_BITS+1:0]   r_den;

    logic [REM_BITS-1:0]     w_shifted;
    logic [REM_BITS-1:0]     w_trial;
    logic [REM_BITS:0]       w_diff;
    logic                    w_ge;

    // Pick the shifted remainder and the trial value for this step
    always_comb begin
        if (r_op == OP_SQRT) begin
            w_shifted = {r_rem[REM_BITS-3:0], r_x[ACC_BITS-1 -: 2]};
            w_trial   = {r_quo[REM_BITS-3:0], 2'b01};
        end else begin
            w_shifted = {r_rem[REM_BITS-2:0], r_x[ACC_BITS-1]};
            w_trial   = REM_BITS'(r_den);
        end
        w_diff = {1'b0, w_shifted} - {1'b0, w_trial};
        w_ge   = ~w_diff[REM_BITS];
    end

    // Load on start, then advance one step a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= (i_cmd.op == OP_SQRT) ? STEP_BITS'(SQRT_STEPS - 1)
                                            : STEP_BITS'(DIV_STEPS - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= i_cmd.op;
            r_x   <= i_num;
            r_den <= i_den;
            r_quo <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[REM_BITS-1:0] : w_shifted;
            r_quo <= {r_quo[ACC_BITS-2:0], w_ge};
            if (r_op == OP_SQRT) begin
                r_x <= {r_x[ACC_BITS-3:0], 2'b00};
            end else begin
                r_x <= {r_x[ACC_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== rtl/stereo_mean_rms_decimator.sv =====
// Top level of the stereo bucket mean / RMS decimator: handshakes, accumulator, sequencer.
//
//  channel   direction  handshake                    payload
//  s (in)    slave      i_s_tvalid / o_s_tready      i_s_tdata: sample_left, sample_right
//  m (out)   master     o_m_tvalid / i_m_tready      o_m_tdata: level, bucket_index
//  cfg       slave      i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A word that does not close a bucket passes through accept, add left and add right.
// A bucket end adds a prepare state, a divide of 48 steps in the shared unit, in RMS mode
// a square root, and a final state that loads the output register and waits out any output stall.
// i_rst_n is synchronous; it clears the accumulator, bucket position and bucket index.
// A stalled output holds the result; input words are still taken until the next bucket end.
`default_nettype none

module stereo_mean_rms_decimator
    import smrd_pkg::*;
#(
    parameter int WIDTH_BITS = smrd_pkg::WIDTH_BITS
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // slave stream
    input  wire                        i_s_tvalid,
    output logic                       o_s_tready,
    input  wire  [2*SAMPLE_BITS-1:0]   i_s_tdata,   // [15:0] sample_left, [31:16] sample_right
    // master stream
    output logic                       o_m_tvalid,
    input  wire                        i_m_tready,
    output logic [OUT_BITS-1:0]        o_m_tdata,   // [16:0] level, [32:17] bucket_index, zeros
    // configuration write
    input  wire                        i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire  [CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  wire  [WIDTH_BITS-1:0]      i_cfg_data
);

    localparam int REM_BITS = (WIDTH_BITS + 3 > ROOT_BITS + 4) ? WIDTH_BITS + 3 : ROOT_BITS + 4;
    localparam logic [LEVEL_BITS-1:0] MAX_LEVEL = LEVEL_BITS'(1) << (SAMPLE_BITS - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACC_L = 3'd1;
    localparam logic [2:0] S_ACC_R = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_SQRT  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]                     r_state;
    logic [WIDTH_BITS-1:0]          r_bw;
    logic [WIDTH_BITS-1:0]          r_thr;
    logic signed [SAMPLE_BITS-1:0]  r_left;
    logic signed [SAMPLE_BITS-1:0]  r_right;
    logic                           r_rms;
    logic [ACC_BITS-1:0]            r_acc;
    logic [WIDTH_BITS-1:0]          r_fp;
    logic [INDEX_BITS-1:0]          r_cnt;
    logic                           r_neg;
    logic [LEVEL_BITS-1:0]          r_level;
    logic                           r_out_valid;
    logic [LEVEL_BITS-1:0]          r_out_level;
    logic [INDEX_BITS-1:0]          r_out_index;

    logic [WIDTH_BITS-1:0]          w_width;
    logic                           w_rms;
    logic [WIDTH_BITS:0]            w_n;
    logic [WIDTH_BITS+1:0]          w_den;
    logic                           w_end;
    logic signed [SAMPLE_BITS-1:0]  w_smp;
    logic signed [2*SAMPLE_BITS-1:0] w_sq;
    logic [ACC_BITS-1:0]            w_term;
    logic [ACC_BITS-1:0]            n_acc;
    logic [ACC_BITS-1:0]            w_mag;
    logic [ACC_BITS-1:0]            w_num;
    logic                           w_load;

    t_iter_cmd                      w_cmd;
    logic                           w_done;
    logic [ACC_BITS-1:0]            w_quo;
    logic [REM_BITS-1:0]            w_rem;
    logic [ROOT_BITS:0]             w_root;
    logic [LEVEL_BITS-1:0]          w_mean_mag;
    logic [LEVEL_BITS-1:0]          w_mean_level;
    logic [LEVEL_BITS-1:0]          w_rms_level;

    // Effective width and mode from the current registers
    assign w_width = (r_bw == '0) ? WIDTH_BITS'(1) : r_bw;
    assign w_rms   = w_width > r_thr;
    assign w_n     = {1'b0, r_fp} + 1'b1;
    assign w_den   = {w_n, 1'b0};
    assign w_end   = w_n >= {1'b0, w_width};

    // Accumulate one channel per cycle: square or raw sample
    assign w_smp  = (r_state == S_ACC_L) ? r_left : r_right;
    assign w_sq   = w_smp * w_smp;
    assign w_term = r_rms ? {{(ACC_BITS - 2*SAMPLE_BITS){1'b0}}, w_sq}
                          : {{(ACC_BITS - SAMPLE_BITS){w_smp[SAMPLE_BITS-1]}}, w_smp};
    assign n_acc  = r_acc + w_term;

    // Dividend: sum of squares, or magnitude of the sum plus half the divisor
    assign w_mag = r_acc[ACC_BITS-1] ? (~r_acc + 1'b1) : r_acc;
    assign w_num = (r_state == S_PREP) ? (r_rms ? r_acc : (w_mag + ACC_BITS'(w_n))) : w_quo;

    // Start the divide after accumulation, the root after an RMS divide
    always_comb begin
        w_cmd.start = 1'b0;
        w_cmd.op    = OP_DIV;
        if (r_state == S_PREP) begin
            w_cmd.start = 1'b1;
        end else if (r_state == S_DIV && w_done && r_rms) begin
            w_cmd.start = 1'b1;
            w_cmd.op    = OP_SQRT;
        end
    end

    smrd_iter #(
        .WIDTH_BITS (WIDTH_BITS),
        .REM_BITS   (REM_BITS)
    ) u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // Saturate and sign the mean; round and saturate the root
    assign w_mean_mag   = (w_quo > ACC_BITS'(MAX_LEVEL)) ? MAX_LEVEL : w_quo[LEVEL_BITS-1:0];
    assign w_mean_level = r_neg ? (~w_mean_mag + 1'b1) : w_mean_mag;
    assign w_root       = {1'b0, w_quo[ROOT_BITS-1:0]}
                        + ((w_rem > REM_BITS'(w_quo[ROOT_BITS-1:0])) ? 1'b1 : 1'b0);
    assign w_rms_level  = (w_root > (ROOT_BITS+1)'(MAX_LEVEL)) ? MAX_LEVEL
                                                              : w_root[LEVEL_BITS-1:0];

    assign w_load = (r_state == S_FIN) && (!r_out_valid || i_m_tready);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw  <= WIDTH_BITS'(BUCKET_WIDTH_RESET);
            r_thr <= WIDTH_BITS'(RMS_THRESHOLD_RESET);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BUCKET_WIDTH:  r_bw  <= i_cfg_data;
                CFG_RMS_THRESHOLD: r_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and bucket state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
            r_fp    <= '0;
            r_cnt   <= '0;
            r_rms   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_rms   <= w_rms;
                        r_state <= S_ACC_L;
                    end
                end
                S_ACC_L: begin
                    r_acc   <= n_acc;
                    r_state <= S_ACC_R;
                end
                S_ACC_R: begin
                    r_acc <= n_acc;
                    if (w_end) begin
                        r_state <= S_PREP;
                    end else begin
                        r_fp    <= w_n[WIDTH_BITS-1:0];
                        r_state <= S_IDLE;
                    end
                end
                S_PREP: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_done) begin
                        r_state <= r_rms ? S_SQRT : S_FIN;
                    end
                end
                S_SQRT: begin
                    if (w_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_load) begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_fp    <= '0;
                        r_acc   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Capture samples, sign and finished level
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_left  <= i_s_tdata[SAMPLE_BITS-1:0];
            r_right <= i_s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
        if (r_state == S_PREP) begin
            r_neg <= r_acc[ACC_BITS-1];
        end
        if (r_state == S_DIV && w_done && !r_rms) begin
            r_level <= w_mean_level;
        end
        if (r_state == S_SQRT && w_done) begin
            r_level <= w_rms_level;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_level <= r_level;
            r_out_index <= r_cnt;
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {{(OUT_BITS - OUT_RAW){1'b0}}, r_out_index, r_out_level};
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire
